### hw/rtl/shal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shal_pkg
// Shared types and constants for the service host admission limiter.
// ----------------------------------------------------------------------------
package shal_pkg;

  localparam int MODE_W     = 2;
  localparam int HOST_ID_W  = 16;
  localparam int TCNT_W     = 16;
  localparam int HCNT_W     = 5;
  localparam int MAX_TASK_W = 17;
  localparam int MAX_HOST_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHECK   = 2'd0,
    MODE_ACQUIRE = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TASKS = 1'b0,
    CFG_MAX_HOSTS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_t;

  // sequencer to slot table
  typedef struct packed {
    logic start;   // clear scan results
    logic issue;   // read one slot
    logic add;     // store host in the first free slot
    logic remove;  // drop the matching slot
  } slot_ctl_t;

  // slot table to sequencer
  typedef struct packed {
    logic hit;
    logic free;
  } slot_res_t;

  localparam logic [MAX_TASK_W-1:0] MAX_TASKS_RST = '1;  // -1, unlimited
  localparam logic [MAX_HOST_W-1:0] MAX_HOSTS_RST = '1;  // -1, unlimited

endpackage
`default_nettype wire

### hw/rtl/shal_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shal_if
// Channel interfaces: request words, result words and register writes.
// ----------------------------------------------------------------------------
interface shal_in_if;
  logic                            valid;
  logic                            ready;
  logic [shal_pkg::MODE_W-1:0]     mode;
  logic [shal_pkg::HOST_ID_W-1:0]  host_id;

  modport source (output valid, output mode, output host_id, input ready);
  modport sink   (input valid, input mode, input host_id, output ready);
endinterface

interface shal_out_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic                            table_full;
  logic [shal_pkg::TCNT_W-1:0]     task_count;
  logic [shal_pkg::HCNT_W-1:0]     host_count;

  modport source (output valid, output ok, output table_full, output task_count,
                  output host_count, input ready);
  modport sink   (input valid, input ok, input table_full, input task_count,
                  input host_count, output ready);
endinterface

interface shal_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [shal_pkg::CFG_IDX_W-1:0]   index;
  logic [shal_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/shal_slot_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shal_slot_scan
// Host slot table: id memory with registered read, valid flops, and the
// one-slot-per-cycle search for a matching and a free slot.
// ----------------------------------------------------------------------------
module shal_slot_scan #(
  parameter int SLOTS = 16,
  parameter int IDW   = 16,
  parameter int IW    = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire shal_pkg::slot_ctl_t ctl,
  input  wire logic [IW-1:0]       idx,
  input  wire logic [IDW-1:0]      id,
  output shal_pkg::slot_res_t      res
);

  logic [IDW-1:0]   mem [SLOTS];
  logic [SLOTS-1:0] slot_vld_r;
  logic [IDW-1:0]   rd_r;
  logic             p_vld_r;
  logic [IW-1:0]    p_idx_r;
  logic             p_sv_r;
  logic             hit_r;
  logic [IW-1:0]    hit_idx_r;
  logic             free_r;
  logic [IW-1:0]    free_idx_r;
  logic             match;
  logic             empty;

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_r <= mem[idx];
    end
    if (ctl.add) begin
      mem[free_idx_r] <= id;
    end
  end

  // compare stage sees the word read in the previous cycle
  assign match = p_vld_r && p_sv_r && (rd_r == id);
  assign empty = p_vld_r && !p_sv_r;

  always_ff @(posedge clk) begin
    p_idx_r <= idx;
    p_sv_r  <= slot_vld_r[idx];
    if (match && !hit_r) begin
      hit_idx_r <= p_idx_r;
    end
    if (empty && !free_r) begin
      free_idx_r <= p_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      p_vld_r    <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      p_vld_r <= ctl.issue;
      if (ctl.start) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (match) begin
          hit_r <= 1'b1;
        end
        if (empty) begin
          free_r <= 1'b1;
        end
      end
      if (ctl.add) begin
        slot_vld_r[free_idx_r] <= 1'b1;
      end
      if (ctl.remove) begin
        slot_vld_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  assign res.hit  = hit_r;
  assign res.free = free_r;

  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.add |-> (free_r && !slot_vld_r[free_idx_r]))
    else $error("host stored over a live slot");
  a_rm_live: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.remove |-> (hit_r && slot_vld_r[hit_idx_r]))
    else $error("host removed from an empty slot");
  a_add_rm: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.add && ctl.remove))
    else $error("add and remove in the same cycle");

endmodule
`default_nettype wire

### hw/rtl/service_host_admission_limiter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// service_host_admission_limiter_core
// Task and distinct-host admission limiter for one service.
//
//   channel  dir  payload                                   handshake
//   in_ch    in   mode, host_id                             valid/ready
//   out_ch   out  ok, table_full, task_count, host_count    valid/ready
//   cfg_ch   in   index, data (max_tasks, max_hosts)        valid/ready
//
// After a request is accepted, the slot table is searched one slot per cycle
// through its single read port; then the read drains, the update is applied
// and the sequencer returns to idle, where the next word is taken.
// Reset (rst_n, synchronous) clears the counters and slot valid bits and
// sets both limits to unlimited. A result waits in the output register
// while the next word is taken; an update stalls only while that register
// is occupied and not being read. Register writes are always taken.
// ----------------------------------------------------------------------------
module service_host_admission_limiter_core #(
  parameter int HOST_SLOTS   = 16,
  parameter int HOST_ID_BITS = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  shal_in_if.sink     in_ch,
  shal_out_if.source  out_ch,
  shal_cfg_if.sink    cfg_ch
);

  localparam int IW  = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
  localparam int IDW = (HOST_ID_BITS < shal_pkg::HOST_ID_W) ? HOST_ID_BITS
                                                              : shal_pkg::HOST_ID_W;
  localparam int HW  = $clog2(HOST_SLOTS + 1);
  localparam int HCW = (HW > shal_pkg::MAX_HOST_W) ? HW : shal_pkg::MAX_HOST_W;

  shal_pkg::state_t                   state_r, state_nxt;
  logic [shal_pkg::MAX_TASK_W-1:0]    max_tasks_r;
  logic [shal_pkg::MAX_HOST_W-1:0]    max_hosts_r;
  logic [shal_pkg::TCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [HCW-1:0]                     held_r, held_nxt;
  logic [shal_pkg::MODE_W-1:0]        mode_r;
  logic [IDW-1:0]                     id_r;
  logic [IW-1:0]                      scan_r;
  logic                               out_valid_r;
  logic                               out_ok_r, out_full_r;
  logic [shal_pkg::TCNT_W-1:0]        out_tcnt_r;
  logic [shal_pkg::HCNT_W-1:0]        out_hcnt_r;

  logic                               in_fire, out_fire, apply_go, scan_last;
  logic                               task_lim, host_lim, ok_nxt, full_nxt;
  logic                               slot_add, slot_rm;
  shal_pkg::slot_ctl_t                ctl;
  shal_pkg::slot_res_t                res;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_valid_r && out_ch.ready;
  assign scan_last = (scan_r == IW'(HOST_SLOTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shal_pkg::ST_IDLE:  if (in_fire) state_nxt = shal_pkg::ST_SCAN;
      shal_pkg::ST_SCAN:  if (scan_last) state_nxt = shal_pkg::ST_DRAIN;
      shal_pkg::ST_DRAIN: state_nxt = shal_pkg::ST_APPLY;
      shal_pkg::ST_APPLY: if (apply_go) state_nxt = shal_pkg::ST_IDLE;
      default:            state_nxt = shal_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    apply_go    = 1'b0;
    ctl.start   = 1'b0;
    ctl.issue   = 1'b0;
    unique case (state_r)
      shal_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.start   = in_ch.valid;
      end
      shal_pkg::ST_SCAN:  ctl.issue = 1'b1;
      shal_pkg::ST_DRAIN: ;
      shal_pkg::ST_APPLY: apply_go = !out_valid_r || out_ch.ready;
      default: ;
    endcase
    ctl.add    = slot_add && apply_go;
    ctl.remove = slot_rm && apply_go;
  end

  // limits as they stand before the request
  assign task_lim = !max_tasks_r[shal_pkg::MAX_TASK_W-1] &&
                    (cnt_r >= max_tasks_r[shal_pkg::TCNT_W-1:0]);
  assign host_lim = !max_hosts_r[shal_pkg::MAX_HOST_W-1] &&
                    (held_r >= HCW'(max_hosts_r[shal_pkg::MAX_HOST_W-2:0]));

  always_comb begin
    ok_nxt   = 1'b0;
    full_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    slot_add = 1'b0;
    slot_rm  = 1'b0;
    unique case (shal_pkg::mode_t'(mode_r))
      shal_pkg::MODE_CHECK: begin
        ok_nxt = !task_lim && !(host_lim && !res.hit);
      end
      shal_pkg::MODE_ACQUIRE: begin
        ok_nxt = !task_lim && !host_lim;
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + shal_pkg::TCNT_W'(1);
        end
        if (!res.hit) begin
          if (res.free) begin
            slot_add = 1'b1;
            held_nxt = held_r + HCW'(1);
          end else begin
            full_nxt = 1'b1;
          end
        end
      end
      shal_pkg::MODE_RELEASE: begin
        ok_nxt = (cnt_r != '0) && res.hit;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - shal_pkg::TCNT_W'(1);
        end
        if (res.hit) begin
          slot_rm = 1'b1;
          if (held_r != '0) begin
            held_nxt = held_r - HCW'(1);
          end
        end
      end
      shal_pkg::MODE_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shal_pkg::ST_IDLE;
      max_tasks_r <= shal_pkg::MAX_TASKS_RST;
      max_hosts_r <= shal_pkg::MAX_HOSTS_RST;
      cnt_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (shal_pkg::cfg_reg_t'(cfg_ch.index))
          shal_pkg::CFG_MAX_TASKS: max_tasks_r <= cfg_ch.data;
          shal_pkg::CFG_MAX_HOSTS: max_hosts_r <= cfg_ch.data[shal_pkg::MAX_HOST_W-1:0];
          default: ;
        endcase
      end
      if (apply_go) begin
        cnt_r       <= cnt_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_ch.mode;
      id_r   <= in_ch.host_id[IDW-1:0];
    end
    if (ctl.start) begin
      scan_r <= '0;
    end else if (ctl.issue) begin
      scan_r <= scan_r + IW'(1);
    end
    if (apply_go) begin
      out_ok_r   <= ok_nxt;
      out_full_r <= full_nxt;
      out_tcnt_r <= cnt_nxt;
      out_hcnt_r <= held_nxt[shal_pkg::HCNT_W-1:0];
    end
  end

  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.table_full = out_full_r;
  assign out_ch.task_count = out_tcnt_r;
  assign out_ch.host_count = out_hcnt_r;

  shal_slot_scan #(
    .SLOTS (HOST_SLOTS),
    .IDW   (IDW),
    .IW    (IW)
  ) u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .idx   (scan_r),
    .id    (id_r),
    .res   (res)
  );

  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HCW'(HOST_SLOTS))
    else $error("host count beyond slot count");
  a_apply_out: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go |=> out_valid_r)
    else $error("result lost after update");
  a_scan_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shal_pkg::ST_SCAN) |=>
      (state_r == shal_pkg::ST_SCAN || state_r == shal_pkg::ST_DRAIN))
    else $error("scan left early");
  a_full_acq: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && full_nxt) |-> (held_r == HCW'(HOST_SLOTS)))
    else $error("table full with free slots");

endmodule
`default_nettype wire
